FILE: src/utf8d_pkg.sv
package utf8d_pkg;

  // Second-byte range rules
  localparam logic [2:0] RULE_ORD = 3'd0;  // 80-BF
  localparam logic [2:0] RULE_E0  = 3'd1;  // A0-BF
  localparam logic [2:0] RULE_ED  = 3'd2;  // 80-9F
  localparam logic [2:0] RULE_F0  = 3'd3;  // 90-BF
  localparam logic [2:0] RULE_F4  = 3'd4;  // 80-8F

  // Configuration register index
  localparam logic REG_OUT_FORMAT = 1'b0;

  // UTF-16 surrogate bases and plane offset
  localparam logic [20:0] HI_SURR_BASE = 21'h00D800;
  localparam logic [20:0] LO_SURR_BASE = 21'h00DC00;
  localparam logic [20:0] PLANE1_BASE  = 21'h010000;

  // One decoded transaction, passed from front to back
  typedef struct packed {
    logic [20:0] point;
    logic        is_pair;
    logic        failed;
    logic        done;
  } entry_t;

endpackage

FILE: src/utf8d_front.sv
module utf8d_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             string_end,
  input  logic             out_format,
  output logic             push,
  output utf8d_pkg::entry_t entry
);
  import utf8d_pkg::*;

  logic [1:0]  bytes_left, bytes_left_next;
  logic [20:0] partial_point, partial_point_next;
  logic [2:0]  second_byte_rule, second_byte_rule_next;
  logic        awaiting_second, awaiting_second_next;
  logic        error_seen, error_seen_next;

  logic        have_point;
  logic [20:0] cp;
  logic        second_ok;
  logic        bad_cont;

  // Range check for the second byte of a sequence
  always_comb begin
    case (second_byte_rule)
      RULE_E0: second_ok = (data_byte >= 8'hA0);
      RULE_ED: second_ok = (data_byte <= 8'h9F);
      RULE_F0: second_ok = (data_byte >= 8'h90);
      RULE_F4: second_ok = (data_byte <= 8'h8F);
      default: second_ok = 1'b1;
    endcase
  end

  assign bad_cont = !(data_byte inside {[8'h80:8'hBF]}) || (awaiting_second && !second_ok);

  // Classify the byte and advance the sequence state
  always_comb begin
    bytes_left_next       = bytes_left;
    partial_point_next    = partial_point;
    second_byte_rule_next = second_byte_rule;
    awaiting_second_next  = awaiting_second;
    error_seen_next       = error_seen;
    have_point            = 1'b0;
    cp                    = '0;
    if (!error_seen) begin
      if (bytes_left == 2'd0) begin
        if (data_byte < 8'h80) begin
          cp         = {13'd0, data_byte};
          have_point = 1'b1;
        end else if (!(data_byte inside {[8'hC2:8'hF4]})) begin
          error_seen_next = 1'b1;
        end else if (data_byte < 8'hE0) begin
          bytes_left_next       = 2'd1;
          partial_point_next    = {16'd0, data_byte[4:0]};
          second_byte_rule_next = RULE_ORD;
          awaiting_second_next  = 1'b1;
        end else if (data_byte < 8'hF0) begin
          bytes_left_next       = 2'd2;
          partial_point_next    = {17'd0, data_byte[3:0]};
          second_byte_rule_next = (data_byte == 8'hE0) ? RULE_E0 :
                                  (data_byte == 8'hED) ? RULE_ED : RULE_ORD;
          awaiting_second_next  = 1'b1;
        end else begin
          bytes_left_next       = 2'd3;
          partial_point_next    = {18'd0, data_byte[2:0]};
          second_byte_rule_next = (data_byte == 8'hF0) ? RULE_F0 :
                                  (data_byte == 8'hF4) ? RULE_F4 : RULE_ORD;
          awaiting_second_next  = 1'b1;
        end
      end else begin
        if (bad_cont) begin
          error_seen_next = 1'b1;
        end else begin
          partial_point_next    = {partial_point[14:0], data_byte[5:0]};
          awaiting_second_next  = 1'b0;
          second_byte_rule_next = RULE_ORD;
          bytes_left_next       = bytes_left - 2'd1;
          if (bytes_left == 2'd1) begin
            cp                 = {partial_point[14:0], data_byte[5:0]};
            have_point         = 1'b1;
            partial_point_next = '0;
          end
        end
      end
    end
  end

  // Build the queue entry for this transaction
  always_comb begin
    push          = 1'b0;
    entry.point   = cp;
    entry.is_pair = out_format && (cp[20:16] != 5'd0);
    entry.failed  = 1'b0;
    entry.done    = string_end;
    if (string_end && (error_seen_next || bytes_left_next != 2'd0)) begin
      push          = accept;
      entry.point   = '0;
      entry.is_pair = 1'b0;
      entry.failed  = 1'b1;
      entry.done    = 1'b1;
    end else if (have_point) begin
      push = accept;
    end
  end

  // Sequence state; string end clears it
  always_ff @(posedge clk) begin
    if (rst || (accept && string_end)) begin
      bytes_left       <= '0;
      partial_point    <= '0;
      second_byte_rule <= RULE_ORD;
      awaiting_second  <= 1'b0;
      error_seen       <= 1'b0;
    end else if (accept) begin
      bytes_left       <= bytes_left_next;
      partial_point    <= partial_point_next;
      second_byte_rule <= second_byte_rule_next;
      awaiting_second  <= awaiting_second_next;
      error_seen       <= error_seen_next;
    end
  end

endmodule

FILE: src/utf8d_queue.sv
module utf8d_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  utf8d_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output utf8d_pkg::entry_t head_entry
);
  import utf8d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign not_empty  = (count != '0);
  assign head_entry = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/utf8d_back.sv
module utf8d_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  utf8d_pkg::entry_t q_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [20:0]       code_unit,
  output logic              failed,
  output logic              string_done
);
  import utf8d_pkg::*;

  logic        load;
  logic        pending;
  logic [20:0] low_unit;
  logic        low_done;
  logic [19:0] offset;
  logic [20:0] diff;

  // Surrogate split of a supplementary point
  assign diff   = q_entry.point - PLANE1_BASE;
  assign offset = diff[19:0];

  assign load = !out_valid || out_ready;
  assign pop  = load && !pending && q_valid;

  // Control: output valid and pending low surrogate
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (load) begin
      if (pending) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        pending   <= q_entry.is_pair;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload and held low surrogate
  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        code_unit   <= low_unit;
        failed      <= 1'b0;
        string_done <= low_done;
      end else if (q_valid) begin
        if (q_entry.is_pair) begin
          code_unit   <= HI_SURR_BASE + {11'd0, offset[19:10]};
          failed      <= 1'b0;
          string_done <= 1'b0;
          low_unit    <= LO_SURR_BASE + {11'd0, offset[9:0]};
          low_done    <= q_entry.done;
        end else begin
          code_unit   <= q_entry.point;
          failed      <= q_entry.failed;
          string_done <= q_entry.done;
        end
      end
    end
  end

endmodule

FILE: src/utf8_validating_decoder.sv
// UTF-8 validating decoder.
// Input channel (in_valid/in_ready, data_byte, string_end): one byte of a
// UTF-8 string per transaction, string_end set on the final byte.
// Output channel (out_valid/out_ready, code_unit, failed, string_done): one
// UTF-32 point, or one UTF-16 unit when out_format is 1 (two transactions
// for a surrogate pair). An illegal or truncated string stops producing
// results and gives one transaction with failed=1, string_done=1 at its end.
// Register out_format sits at APB byte address 0; write it only while idle.
// A result is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; a surrogate
// pair holds the output stage for two transactions, absorbed by the
// QUEUE_DEPTH-entry queue between the byte classifier and the output stage.
// When the receiver stalls, the output register holds and the queue fills;
// in_ready drops only once the queue is full.
// Reset (rst, synchronous) clears out_format, the sequence state, the queue
// pointers and count, and the output valid and pending flags.
module utf8_validating_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        string_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_unit,
  output logic        failed,
  output logic        string_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import utf8d_pkg::*;

  logic   out_format;
  logic   accept;
  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t push_entry;
  entry_t head_entry;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUT_FORMAT) ? {31'd0, out_format} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_format <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_OUT_FORMAT) begin
      out_format <= pwdata[0];
    end
  end

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  utf8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .string_end (string_end),
    .out_format (out_format),
    .push       (push),
    .entry      (push_entry)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (q_valid),
    .head_entry (head_entry)
  );

  utf8d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (head_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_unit   (code_unit),
    .failed      (failed),
    .string_done (string_done)
  );

endmodule
